/* hw/rtl/key_press_hold_detector_assert.svh */
// assertion macros for the key press / hold detector
// expects clk and rst_n in the scope where a macro is used
`ifndef KEY_PRESS_HOLD_DETECTOR_ASSERT_SVH
`define KEY_PRESS_HOLD_DETECTOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KPHD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define KPHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/kphd_pkg.sv */
// shared types, codes and reset constants of the key press / hold detector
// no dependencies
package kphd_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int CNT_W = 16;
  localparam int KEY_W = 8;
  localparam int CH_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] JITTER_RST = 16'd2;
  localparam logic [CNT_W-1:0] PRESS_RST = 16'd50;
  localparam logic [CNT_W-1:0] LONG_RST = 16'd100;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_JITTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_JITTER = 3'd1,
    PH_PRESSED = 3'd2,
    PH_WAIT = 3'd3,
    PH_LONG = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_PRESS = 2'd0,
    EV_RELEASE = 2'd1,
    EV_HOLD = 2'd2,
    EV_HOLD_REL = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic key_present;
    logic [KEY_W-1:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [KEY_W-1:0] event_key;
    logic [CH_W-1:0] event_channel;
  } out_item_t;

  typedef struct packed {
    phase_t phase;
    logic [CNT_W-1:0] wait_count;
    logic [KEY_W-1:0] latched_key;
  } chan_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] jitter_ticks;
    logic [CNT_W-1:0] press_ticks;
    logic [CNT_W-1:0] long_ticks;
  } cfg_t;

  localparam chan_state_t CHAN_RST = '{phase: PH_IDLE, wait_count: '0, latched_key: '0};

endpackage

/* hw/rtl/kphd_stream_if.sv */
// valid / ready stream channel with a typed payload
// payload types come from kphd_pkg
interface kphd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/kphd_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module kphd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic clk,
  input  logic wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/kphd_cfg_regs.sv */
// timing registers for the debounce and hold phases
// uses kphd_pkg for the register codes and reset values
module kphd_cfg_regs (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [kphd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kphd_pkg::CNT_W-1:0] cfg_wdata,
  output kphd_pkg::cfg_t cfg
);

  kphd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jitter_ticks <= kphd_pkg::JITTER_RST;
      cfg_r.press_ticks <= kphd_pkg::PRESS_RST;
      cfg_r.long_ticks <= kphd_pkg::LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        kphd_pkg::CFG_JITTER: cfg_r.jitter_ticks <= cfg_wdata;
        kphd_pkg::CFG_PRESS: cfg_r.press_ticks <= cfg_wdata;
        kphd_pkg::CFG_LONG: cfg_r.long_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/kphd_step.sv */
// per-channel phase update for one scan tick, purely combinational
// uses kphd_pkg for state, item and event types
module kphd_step (
  input  kphd_pkg::chan_state_t cur,
  input  kphd_pkg::in_item_t item,
  input  kphd_pkg::cfg_t cfg,
  output kphd_pkg::chan_state_t nxt,
  output logic ev_valid,
  output kphd_pkg::out_item_t ev
);

  logic [kphd_pkg::CNT_W-1:0] cnt_inc;

  // counter saturates at its maximum
  assign cnt_inc = (cur.wait_count == kphd_pkg::CNT_MAX) ? cur.wait_count
                                                         : cur.wait_count + 16'd1;

  always_comb begin
    nxt = cur;
    ev_valid = 1'b0;
    ev.event_kind = kphd_pkg::EV_PRESS;
    ev.event_key = item.key_code;
    ev.event_channel = item.channel;
    case (cur.phase)
      kphd_pkg::PH_IDLE: begin
        if (item.key_present) begin
          nxt.latched_key = item.key_code;
          nxt.wait_count = '0;
          nxt.phase = kphd_pkg::PH_JITTER;
        end
      end
      kphd_pkg::PH_JITTER: begin
        if (!item.key_present) begin
          nxt = kphd_pkg::CHAN_RST;
        end else if (cur.wait_count >= cfg.jitter_ticks) begin
          nxt.wait_count = '0;
          nxt.latched_key = item.key_code;
          nxt.phase = kphd_pkg::PH_PRESSED;
          ev_valid = 1'b1;
          ev.event_kind = kphd_pkg::EV_PRESS;
        end else begin
          nxt.wait_count = cnt_inc;
        end
      end
      kphd_pkg::PH_PRESSED: begin
        if (!item.key_present) begin
          nxt = kphd_pkg::CHAN_RST;
          ev_valid = 1'b1;
          ev.event_kind = kphd_pkg::EV_RELEASE;
          ev.event_key = cur.latched_key;
        end else if (cur.wait_count >= cfg.press_ticks) begin
          nxt.wait_count = '0;
          nxt.phase = kphd_pkg::PH_WAIT;
        end else begin
          nxt.wait_count = cnt_inc;
        end
      end
      kphd_pkg::PH_WAIT: begin
        if (!item.key_present) begin
          nxt = kphd_pkg::CHAN_RST;
          ev_valid = 1'b1;
          ev.event_kind = kphd_pkg::EV_RELEASE;
          ev.event_key = cur.latched_key;
        end else if (cur.wait_count >= cfg.long_ticks) begin
          nxt.wait_count = '0;
          nxt.latched_key = item.key_code;
          nxt.phase = kphd_pkg::PH_LONG;
          ev_valid = 1'b1;
          ev.event_kind = kphd_pkg::EV_HOLD;
        end else begin
          nxt.wait_count = cnt_inc;
        end
      end
      kphd_pkg::PH_LONG: begin
        if (!item.key_present) begin
          nxt = kphd_pkg::CHAN_RST;
          ev_valid = 1'b1;
          ev.event_kind = kphd_pkg::EV_HOLD_REL;
          ev.event_key = cur.latched_key;
        end
      end
      default: begin
        // meaningless phase code drops back to idle silently
        nxt.wait_count = '0;
        nxt.phase = kphd_pkg::PH_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/key_press_hold_detector.sv */
// key press / hold detector: a request is registered in the stage, its event in the output
// register; throughput one scan tick per cycle unless the output stalls; the channel
// state ram read-modify-write sets it, with a bypass register for back-to-back ticks
// on the same channel; reset (synchronous, active low) clears the per-channel valid
// bits at once, so every channel reads idle right away; timing registers return to defaults
module key_press_hold_detector #(
  parameter int NUM_CHANNELS = kphd_pkg::NUM_CHANNELS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  kphd_stream_if.sink in_chan,
  kphd_stream_if.source out_chan,
  input  logic cfg_we,
  input  logic [kphd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kphd_pkg::CNT_W-1:0] cfg_wdata
);

`include "key_press_hold_detector_assert.svh"

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SW = $bits(kphd_pkg::chan_state_t);

  kphd_pkg::cfg_t cfg;
  kphd_pkg::in_item_t in_item;
  kphd_pkg::in_item_t s1_item_r;
  kphd_pkg::chan_state_t cur, nxt, fwd_data_r;
  kphd_pkg::out_item_t ev, out_data_r;
  logic [SW-1:0] ram_rd;
  logic [AW+kphd_pkg::CH_W-1:0] in_ch_wide;
  logic [AW-1:0] in_addr, s1_addr_r;
  logic in_range, s1_range_r;
  logic in_fire, s1_go, wr;
  logic s1_valid_r, out_valid_r, fwd_valid_r, s1_chvalid_r;
  logic ev_valid;
  logic [NUM_CHANNELS-1:0] chan_valid_r;

  kphd_cfg_regs u_cfg (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg(cfg)
  );

  assign in_item = in_chan.data;
  assign in_ch_wide = {{AW{1'b0}}, in_item.channel};
  assign in_addr = in_ch_wide[AW-1:0];
  assign in_range = ({30'd0, in_item.channel} < 32'(NUM_CHANNELS));

  assign s1_go = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;
  assign in_fire = in_chan.valid && in_chan.ready;
  assign wr = s1_go && s1_range_r;

  kphd_ram #(
    .WIDTH(SW),
    .DEPTH(NUM_CHANNELS),
    .AW(AW)
  ) u_state_ram (
    .clk(clk),
    .wr_en(wr),
    .wr_addr(s1_addr_r),
    .wr_data(nxt),
    .rd_en(in_fire),
    .rd_addr(in_addr),
    .rd_data(ram_rd)
  );

  // bypass wins over the ram; a never-written channel reads as idle
  always_comb begin
    if (fwd_valid_r) begin
      cur = fwd_data_r;
    end else if (s1_chvalid_r) begin
      cur = kphd_pkg::chan_state_t'(ram_rd);
    end else begin
      cur = kphd_pkg::CHAN_RST;
    end
  end

  kphd_step u_step (
    .cur(cur),
    .item(s1_item_r),
    .cfg(cfg),
    .nxt(nxt),
    .ev_valid(ev_valid),
    .ev(ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      chan_valid_r <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        fwd_valid_r <= wr && (s1_addr_r == in_addr);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
        fwd_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= ev_valid && s1_range_r;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr) begin
        chan_valid_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
      s1_addr_r <= in_addr;
      s1_range_r <= in_range;
      s1_chvalid_r <= in_range && chan_valid_r[in_addr];
      fwd_data_r <= nxt;
    end
    if (s1_go) begin
      out_data_r <= ev;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data = out_data_r;

  `KPHD_ASSERT_NOW(a_no_accept_on_stall, s1_valid_r && !s1_go, !in_fire,
                   "request accepted while stage is stalled")
  `KPHD_ASSERT_NOW(a_fwd_needs_stage, fwd_valid_r, s1_valid_r,
                   "bypass set without a request in the stage")
  `KPHD_ASSERT_NEXT(a_written_is_valid, wr, chan_valid_r[$past(s1_addr_r)],
                    "written channel not marked valid")
  `KPHD_ASSERT_NOW(a_press_from_jitter,
                   s1_go && ev_valid && (ev.event_kind == kphd_pkg::EV_PRESS),
                   cur.phase == kphd_pkg::PH_JITTER,
                   "press event outside the jitter phase")

endmodule

/* tb/sv/tb_key_press_hold_detector.sv */
// self-checking testbench for key_press_hold_detector: directed table, a stall-free long hold,
// then random key sessions; untyped requests are scored by a per-channel press / hold
// predictor kept in this file; depends on kphd_pkg, kphd_stream_if and the detector rtl
module tb_key_press_hold_detector;

  localparam int NUM_CH = kphd_pkg::NUM_CHANNELS_DEF;
  localparam logic [kphd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_PCT = 34;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_SHOWN = 10;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_TICKS = 85;
  localparam int STEADY_TICKS = 64;

  typedef enum logic {ROW_TICK, ROW_TIMING} row_kind_t;

  typedef struct {
    row_kind_t kind;
    kphd_pkg::in_item_t item;
    logic typed;
    logic has_ev;
    kphd_pkg::out_item_t ev;
    kphd_pkg::cfg_t timing;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [kphd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [kphd_pkg::CNT_W-1:0] cfg_wdata = '0;

  kphd_stream_if #(.T(kphd_pkg::in_item_t)) in_if ();
  kphd_stream_if #(.T(kphd_pkg::out_item_t)) out_if ();

  key_press_hold_detector uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  kphd_pkg::chan_state_t key_chan[NUM_CH];
  kphd_pkg::cfg_t key_timing;
  kphd_pkg::out_item_t pending_events[$];
  dir_row_t dir_rows[$];

  int fail_count = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;

  function automatic void chan_to_idle(int c);
    key_chan[c].phase = kphd_pkg::PH_IDLE;
    key_chan[c].wait_count = '0;
    key_chan[c].latched_key = '0;
  endfunction

  function automatic void chan_count_up(int c);
    if (key_chan[c].wait_count != kphd_pkg::CNT_MAX) begin
      key_chan[c].wait_count = key_chan[c].wait_count + kphd_pkg::CNT_W'(1);
    end
  endfunction

  function automatic void key_event_predict(input kphd_pkg::in_item_t t, output logic fired,
                                            output kphd_pkg::out_item_t ev);
    int c;
    c = int'(t.channel);
    fired = 1'b0;
    ev = '0;
    ev.event_channel = t.channel;
    if (c >= NUM_CH) return;
    case (key_chan[c].phase)
      kphd_pkg::PH_IDLE: begin
        if (t.key_present) begin
          key_chan[c].latched_key = t.key_code;
          key_chan[c].wait_count = '0;
          key_chan[c].phase = kphd_pkg::PH_JITTER;
        end
      end
      kphd_pkg::PH_JITTER: begin
        if (!t.key_present) begin
          chan_to_idle(c);
        end else if (key_chan[c].wait_count >= key_timing.jitter_ticks) begin
          key_chan[c].wait_count = '0;
          key_chan[c].latched_key = t.key_code;
          key_chan[c].phase = kphd_pkg::PH_PRESSED;
          fired = 1'b1;
          ev.event_kind = kphd_pkg::EV_PRESS;
          ev.event_key = t.key_code;
        end else begin
          chan_count_up(c);
        end
      end
      kphd_pkg::PH_PRESSED, kphd_pkg::PH_WAIT: begin
        if (!t.key_present) begin
          fired = 1'b1;
          ev.event_kind = kphd_pkg::EV_RELEASE;
          ev.event_key = key_chan[c].latched_key;
          chan_to_idle(c);
        end else if (key_chan[c].phase == kphd_pkg::PH_PRESSED) begin
          if (key_chan[c].wait_count >= key_timing.press_ticks) begin
            key_chan[c].wait_count = '0;
            key_chan[c].phase = kphd_pkg::PH_WAIT;
          end else begin
            chan_count_up(c);
          end
        end else if (key_chan[c].wait_count >= key_timing.long_ticks) begin
          key_chan[c].wait_count = '0;
          key_chan[c].latched_key = t.key_code;
          key_chan[c].phase = kphd_pkg::PH_LONG;
          fired = 1'b1;
          ev.event_kind = kphd_pkg::EV_HOLD;
          ev.event_key = t.key_code;
        end else begin
          chan_count_up(c);
        end
      end
      kphd_pkg::PH_LONG: begin
        if (!t.key_present) begin
          fired = 1'b1;
          ev.event_kind = kphd_pkg::EV_HOLD_REL;
          ev.event_key = key_chan[c].latched_key;
          chan_to_idle(c);
        end
      end
      default: begin
        key_chan[c].wait_count = '0;
        key_chan[c].phase = kphd_pkg::PH_IDLE;
      end
    endcase
  endfunction

  function automatic void note_failure(string msg);
    if (fail_count < MAX_SHOWN) $display("%s", msg);
    fail_count++;
  endfunction

  // directed table builders
  function automatic void row_add(logic [kphd_pkg::CH_W-1:0] ch, logic pres,
                                  logic [kphd_pkg::KEY_W-1:0] key,
                                  logic typed, logic has_ev, logic [1:0] kind,
                                  logic [kphd_pkg::KEY_W-1:0] ev_key);
    dir_row_t r;
    r.kind = ROW_TICK;
    r.item = '{channel: ch, key_present: pres, key_code: key};
    r.typed = typed;
    r.has_ev = has_ev;
    r.ev = '{event_kind: kind, event_key: ev_key, event_channel: ch};
    r.timing = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_timing(logic [kphd_pkg::CNT_W-1:0] j,
                                     logic [kphd_pkg::CNT_W-1:0] p,
                                     logic [kphd_pkg::CNT_W-1:0] l);
    dir_row_t r;
    r = '{kind: ROW_TIMING, item: '0, typed: 1'b0, has_ev: 1'b0, ev: '0,
          timing: '{jitter_ticks: j, press_ticks: p, long_ticks: l}};
    dir_rows.push_back(r);
  endfunction

  // result side: random stalls, compare against the oldest expected event
  always @(posedge clk) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    kphd_pkg::out_item_t exp_ev;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        note_failure($sformatf("unexpected event: kind %0d key %02h ch %0d",
                               out_if.data.event_kind, out_if.data.event_key,
                               out_if.data.event_channel));
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_if.data.event_kind !== exp_ev.event_kind ||
            out_if.data.event_key !== exp_ev.event_key ||
            out_if.data.event_channel !== exp_ev.event_channel) begin
          note_failure($sformatf(
            "event mismatch: expected kind %0d key %02h ch %0d, got kind %0d key %02h ch %0d",
            exp_ev.event_kind, exp_ev.event_key, exp_ev.event_channel,
            out_if.data.event_kind, out_if.data.event_key, out_if.data.event_channel));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic push_tick(input kphd_pkg::in_item_t t, input logic typed,
                           input logic typed_has, input kphd_pkg::out_item_t typed_ev);
    logic fired;
    kphd_pkg::out_item_t ev;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= t;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    key_event_predict(t, fired, ev);
    if (typed) begin
      fired = typed_has;
      ev = typed_ev;
    end
    if (fired) pending_events.push_back(ev);
  endtask

  // always crosses at least one edge, so valid never gets two assignments in a step
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kphd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kphd_pkg::CNT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_timing(input kphd_pkg::cfg_t tm);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // the unused index must leave the timing alone
    write_reg(CFG_UNUSED, kphd_pkg::CNT_W'($urandom));
    write_reg(kphd_pkg::CFG_JITTER, tm.jitter_ticks);
    write_reg(kphd_pkg::CFG_PRESS, tm.press_ticks);
    write_reg(kphd_pkg::CFG_LONG, tm.long_ticks);
    cfg_we <= 1'b0;
    key_timing = tm;
  endtask

  initial begin
    kphd_pkg::in_item_t it;
    kphd_pkg::cfg_t tm;
    int hold_left[NUM_CH];
    logic [kphd_pkg::KEY_W-1:0] session_key[NUM_CH];
    int ch;
    int roll;
    int span;

    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    key_timing = '{jitter_ticks: kphd_pkg::JITTER_RST, press_ticks: kphd_pkg::PRESS_RST,
                   long_ticks: kphd_pkg::LONG_RST};
    for (int i = 0; i < NUM_CH; i++) begin
      key_chan[i] = kphd_pkg::CHAN_RST;
      hold_left[i] = 0;
      session_key[i] = '0;
    end

    // default timing: jitter, press, release from pressed, jitter abort
    row_add(2'd0, 1'b1, 8'h00, 1'b1, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd0, 1'b1, 8'hFF, 1'b1, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd0, 1'b1, 8'hFF, 1'b1, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd0, 1'b1, 8'hA5, 1'b1, 1'b1, kphd_pkg::EV_PRESS, 8'hA5);
    row_add(2'd0, 1'b0, 8'hFF, 1'b1, 1'b1, kphd_pkg::EV_RELEASE, 8'hA5);
    row_add(2'd3, 1'b1, 8'h5A, 1'b1, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd3, 1'b0, 8'hFF, 1'b1, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd2, 1'b0, 8'h00, 1'b1, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    // zero timing: every phase moves on at the first tick
    row_timing(16'd0, 16'd0, 16'd0);
    row_add(2'd1, 1'b1, 8'h11, 1'b1, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd1, 1'b1, 8'h22, 1'b1, 1'b1, kphd_pkg::EV_PRESS, 8'h22);
    row_add(2'd1, 1'b1, 8'h33, 1'b1, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd1, 1'b1, 8'h44, 1'b1, 1'b1, kphd_pkg::EV_HOLD, 8'h44);
    row_add(2'd1, 1'b1, 8'h55, 1'b1, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd1, 1'b0, 8'h66, 1'b1, 1'b1, kphd_pkg::EV_HOLD_REL, 8'h44);
    row_add(2'd2, 1'b1, 8'h01, 1'b1, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd2, 1'b1, 8'h02, 1'b1, 1'b1, kphd_pkg::EV_PRESS, 8'h02);
    row_add(2'd2, 1'b1, 8'h03, 1'b1, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd2, 1'b0, 8'h04, 1'b1, 1'b1, kphd_pkg::EV_RELEASE, 8'h02);
    // interleaved channels, scored by the predictor
    row_timing(16'd1, 16'd1, 16'd1);
    row_add(2'd0, 1'b1, 8'h80, 1'b0, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd3, 1'b1, 8'h7F, 1'b0, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd0, 1'b1, 8'h81, 1'b0, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd3, 1'b1, 8'h01, 1'b0, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd0, 1'b1, 8'h82, 1'b0, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd3, 1'b0, 8'hC3, 1'b0, 1'b0, kphd_pkg::EV_PRESS, 8'h00);
    row_add(2'd0, 1'b0, 8'h3C, 1'b0, 1'b0, kphd_pkg::EV_PRESS, 8'h00);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_TIMING) set_timing(dir_rows[i].timing);
      else push_tick(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].has_ev, dir_rows[i].ev);
    end

    // widest timing on one channel, both sides without stalls
    set_timing('{jitter_ticks: kphd_pkg::CNT_MAX, press_ticks: kphd_pkg::CNT_MAX,
                 long_ticks: kphd_pkg::CNT_MAX});
    steady = 1'b1;
    for (int n = 0; n <= STEADY_TICKS; n++) begin
      it.channel = 2'd2;
      it.key_present = (n != STEADY_TICKS);
      it.key_code = kphd_pkg::KEY_W'($urandom);
      push_tick(it, 1'b0, 1'b0, '0);
    end
    steady = 1'b0;

    // random key sessions per channel, with some noise and cut-short holds
    for (int p = 0; p < RAND_PHASES; p++) begin
      tm.jitter_ticks = kphd_pkg::CNT_W'($urandom_range(0, 4));
      tm.press_ticks = kphd_pkg::CNT_W'($urandom_range(0, 8));
      tm.long_ticks = kphd_pkg::CNT_W'($urandom_range(0, 8));
      set_timing(tm);
      span = int'(tm.jitter_ticks) + int'(tm.press_ticks) + int'(tm.long_ticks) + 6;
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (n == PHASE_TICKS / 2) hold_until_drained();
        ch = $urandom_range(0, NUM_CH - 1);
        roll = $urandom_range(0, 99);
        it.channel = kphd_pkg::CH_W'(ch);
        if (roll < 12) begin
          it.key_present = 1'($urandom);
          it.key_code = kphd_pkg::KEY_W'($urandom);
        end else if (hold_left[ch] > 0) begin
          it.key_present = 1'b1;
          it.key_code = (roll < 20) ? kphd_pkg::KEY_W'($urandom) : session_key[ch];
          hold_left[ch]--;
        end else begin
          it.key_present = 1'b0;
          it.key_code = kphd_pkg::KEY_W'($urandom);
          hold_left[ch] = $urandom_range(0, span);
          session_key[ch] = kphd_pkg::KEY_W'($urandom);
        end
        push_tick(it, 1'b0, 1'b0, '0);
      end
    end

    in_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
